FILE: hdl/aim_angles_from_points_defines.svh
// assertion macros for the aim angle block
`ifndef AIM_ANGLES_FROM_POINTS_DEFINES_SVH
`define AIM_ANGLES_FROM_POINTS_DEFINES_SVH

`define AAFP_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

`define AAFP_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

FILE: hdl/aafp_pkg.sv
package aafp_pkg;

    localparam int CORDIC_STAGES   = 16;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int ACC_FRAC        = 20;
    localparam int COORD_W         = 24;
    localparam int DIFF_W          = 25;
    localparam int SQ_W            = 52;
    localparam int ROOT_W          = 27;
    localparam int VEC_W           = 40;
    localparam int ACC_W           = 32;
    localparam int MAX_STAGES      = 32;

    function automatic logic signed [ACC_W-1:0] atan_deg(input int i);
        logic signed [ACC_W-1:0] t;
        unique case (i)
            0: t = 32'sd47185920;  1: t = 32'sd27855475;  2: t = 32'sd14718068;
            3: t = 32'sd7471121;   4: t = 32'sd3750058;   5: t = 32'sd1876857;
            6: t = 32'sd938658;    7: t = 32'sd469357;    8: t = 32'sd234682;
            9: t = 32'sd117342;    10: t = 32'sd58671;    11: t = 32'sd29335;
            12: t = 32'sd14668;    13: t = 32'sd7334;     14: t = 32'sd3667;
            15: t = 32'sd1833;     16: t = 32'sd917;      17: t = 32'sd458;
            18: t = 32'sd229;      19: t = 32'sd115;      20: t = 32'sd57;
            21: t = 32'sd29;       22: t = 32'sd14;       23: t = 32'sd7;
            24: t = 32'sd4;        25: t = 32'sd2;        26: t = 32'sd1;
            default: t = '0;
        endcase
        return t;
    endfunction

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ACC_W-1:0] z;
    } t_vec;

endpackage

FILE: hdl/aim_angles_from_points.sv
// channel  | ports                                  | dir
// command  | start, busy, i_src_*, i_dst_*          | in, busy out
// result   | o_valid, o_yaw, o_pitch, o_distance,    | out
//          | o_coincident                           |
// one beat accepted per cycle; busy is always low
// pipeline: difference register, 27 square root cells, root register,
// cordic pre-stage, CORDIC_STAGES cordic cells (capped at MAX_STAGES), output register
// reset clears the valid pipe only; the receiver cannot stall
`include "aim_angles_from_points_defines.svh"
module aim_angles_from_points #(
    parameter int CORDIC_STAGES   = aafp_pkg::CORDIC_STAGES,
    parameter int ANGLE_FRAC_BITS = aafp_pkg::ANGLE_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [23:0] i_src_x,
    input  logic signed [23:0] i_src_y,
    input  logic signed [23:0] i_src_z,
    input  logic signed [23:0] i_dst_x,
    input  logic signed [23:0] i_dst_y,
    input  logic signed [23:0] i_dst_z,
    output logic        o_valid,
    output logic [15:0] o_yaw,
    output logic signed [14:0] o_pitch,
    output logic [24:0] o_distance,
    output logic        o_coincident
);
    localparam int SW = aafp_pkg::SQ_W + 2;
    localparam int SQC = SW / 2;
    localparam int NS = (CORDIC_STAGES > aafp_pkg::MAX_STAGES) ?
                        aafp_pkg::MAX_STAGES : CORDIC_STAGES;
    localparam int CL = NS + 1;
    localparam int LAT = 1 + SQC + 1 + CL + 1;
    localparam int SH = aafp_pkg::ACC_FRAC - ANGLE_FRAC_BITS;

    logic [LAT-1:0] r_vld;
    logic signed [aafp_pkg::DIFF_W-1:0] r_dx, r_dy, r_dz;
    logic [SW-1:0] hr [0:SQC];
    logic [SW-1:0] hs [0:SQC];
    logic [SW-1:0] dr [0:SQC];
    logic [SW-1:0] ds [0:SQC];
    logic signed [aafp_pkg::DIFF_W-1:0] dxp [0:SQC];
    logic signed [aafp_pkg::DIFF_W-1:0] dyp [0:SQC];
    logic signed [aafp_pkg::DIFF_W-1:0] dzp [0:SQC];
    logic [aafp_pkg::DIFF_W*2-1:0] sqx, sqy, sqz;
    logic [aafp_pkg::ROOT_W-1:0] r_h, r_d;
    logic signed [aafp_pkg::ROOT_W-1:0] r_dx2, r_dy2, r_dz2;
    logic [aafp_pkg::ROOT_W-1:0] d_line [0:CL];
    logic same_line [0:CL];
    logic signed [aafp_pkg::ACC_W-1:0] za, zb;
    logic signed [aafp_pkg::ACC_W+1:0] ya, pa, yawv, pv, plim, full;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        r_dx <= aafp_pkg::DIFF_W'(i_dst_x) - aafp_pkg::DIFF_W'(i_src_x);
        r_dy <= aafp_pkg::DIFF_W'(i_dst_y) - aafp_pkg::DIFF_W'(i_src_y);
        r_dz <= aafp_pkg::DIFF_W'(i_dst_z) - aafp_pkg::DIFF_W'(i_src_z);
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start};
        end
    end

    assign sqx = unsigned'((aafp_pkg::DIFF_W*2)'(r_dx) * (aafp_pkg::DIFF_W*2)'(r_dx));
    assign sqy = unsigned'((aafp_pkg::DIFF_W*2)'(r_dy) * (aafp_pkg::DIFF_W*2)'(r_dy));
    assign sqz = unsigned'((aafp_pkg::DIFF_W*2)'(r_dz) * (aafp_pkg::DIFF_W*2)'(r_dz));
    assign hr[0] = SW'(sqx) + SW'(sqy);
    assign dr[0] = SW'(sqx) + SW'(sqy) + SW'(sqz);
    assign hs[0] = '0;
    assign ds[0] = '0;
    assign dxp[0] = r_dx;
    assign dyp[0] = r_dy;
    assign dzp[0] = r_dz;

    for (genvar g = 0; g < SQC; g++) begin : g_root
        aafp_sqrt_cell #(.STEP(g)) u_h (
            .i_clk(i_clk), .i_rem(hr[g]), .i_res(hs[g]), .o_rem(hr[g+1]), .o_res(hs[g+1])
        );
        aafp_sqrt_cell #(.STEP(g)) u_d (
            .i_clk(i_clk), .i_rem(dr[g]), .i_res(ds[g]), .o_rem(dr[g+1]), .o_res(ds[g+1])
        );
        always_ff @(posedge i_clk) begin
            dxp[g+1] <= dxp[g];
            dyp[g+1] <= dyp[g];
            dzp[g+1] <= dzp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_h <= aafp_pkg::ROOT_W'(hs[SQC] + ((hr[SQC] > hs[SQC]) ? SW'(1) : SW'(0)));
        r_d <= aafp_pkg::ROOT_W'(ds[SQC] + ((dr[SQC] > ds[SQC]) ? SW'(1) : SW'(0)));
        r_dx2 <= aafp_pkg::ROOT_W'(dxp[SQC]);
        r_dy2 <= aafp_pkg::ROOT_W'(dyp[SQC]);
        r_dz2 <= aafp_pkg::ROOT_W'(dzp[SQC]);
        same_line[0] <= (dxp[SQC] == 0) && (dyp[SQC] == 0) && (dzp[SQC] == 0);
    end

    assign d_line[0] = r_d;
    for (genvar g = 0; g < CL; g++) begin : g_dl
        always_ff @(posedge i_clk) begin
            d_line[g+1] <= d_line[g];
            same_line[g+1] <= same_line[g];
        end
    end

    aafp_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk(i_clk), .i_y(r_dx2), .i_x(r_dy2), .o_z(za)
    );
    aafp_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk(i_clk), .i_y(r_dz2), .i_x(signed'(r_h)), .o_z(zb)
    );

    always_comb begin
        full = (aafp_pkg::ACC_W+2)'(180) <<< ANGLE_FRAC_BITS;
        plim = (aafp_pkg::ACC_W+2)'(90) <<< ANGLE_FRAC_BITS;
        ya = ((aafp_pkg::ACC_W+2)'(za) + ((aafp_pkg::ACC_W+2)'(1) <<< (SH - 1))) >>> SH;
        pa = ((aafp_pkg::ACC_W+2)'(zb) + ((aafp_pkg::ACC_W+2)'(1) <<< (SH - 1))) >>> SH;
        yawv = full - ya;
        if (yawv < 0) yawv = '0;
        if (yawv > 2 * full) yawv = 2 * full;
        pv = pa;
        if (pv > plim) pv = plim;
        if (pv < -plim) pv = -plim;
        if (same_line[CL]) pv = '0;
    end

    always_ff @(posedge i_clk) begin
        o_yaw <= yawv[15:0];
        o_pitch <= pv[14:0];
        o_distance <= d_line[CL][24:0];
        o_coincident <= same_line[CL];
    end

    assign o_valid = r_vld[LAT-1];

    `AAFP_ASSERT_IMPL(a_busy_low, i_clk, i_rst_n, 1'b1, !busy)
    `AAFP_ASSERT_NEXT(a_vld_shift, i_clk, i_rst_n, r_vld[LAT-2], o_valid)
    `AAFP_ASSERT_IMPL(a_coin_pitch, i_clk, i_rst_n, o_valid && o_coincident, o_pitch == 0)
    `AAFP_ASSERT_IMPL(a_coin_dist, i_clk, i_rst_n, o_valid && o_coincident, o_distance == 0)
endmodule

FILE: hdl/aafp_sqrt_cell.sv
module aafp_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                         i_clk,
    input  logic [aafp_pkg::SQ_W+1:0]    i_rem,
    input  logic [aafp_pkg::SQ_W+1:0]    i_res,
    output logic [aafp_pkg::SQ_W+1:0]    o_rem,
    output logic [aafp_pkg::SQ_W+1:0]    o_res
);
    localparam int W = aafp_pkg::SQ_W + 2;
    localparam logic [W-1:0] BIT = (W)'(1) << (W - 2 - 2 * STEP);

    logic [W-1:0] n_rem, n_res;
    logic [W-1:0] r_rem, r_res;

    always_comb begin
        if (i_rem >= i_res + BIT) begin
            n_rem = i_rem - (i_res + BIT);
            n_res = (i_res >> 1) + BIT;
        end else begin
            n_rem = i_rem;
            n_res = i_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_res <= n_res;
    end

    assign o_rem = r_rem;
    assign o_res = r_res;
endmodule

FILE: hdl/aafp_cordic_cell.sv
module aafp_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  aafp_pkg::t_vec i_vec,
    output aafp_pkg::t_vec o_vec
);
    aafp_pkg::t_vec n_vec, r_vec;
    logic signed [aafp_pkg::VEC_W-1:0] xs, ys;

    always_comb begin
        xs = i_vec.x >>> STEP;
        ys = i_vec.y >>> STEP;
        if (i_vec.y >= 0) begin
            n_vec.x = i_vec.x + ys;
            n_vec.y = i_vec.y - xs;
            n_vec.z = i_vec.z + aafp_pkg::atan_deg(STEP);
        end else begin
            n_vec.x = i_vec.x - ys;
            n_vec.y = i_vec.y + xs;
            n_vec.z = i_vec.z - aafp_pkg::atan_deg(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
    end

    assign o_vec = r_vec;
endmodule

FILE: hdl/aafp_cordic.sv
module aafp_cordic #(
    parameter int STAGES = aafp_pkg::CORDIC_STAGES
) (
    input  logic                              i_clk,
    input  logic signed [aafp_pkg::ROOT_W-1:0] i_y,
    input  logic signed [aafp_pkg::ROOT_W-1:0] i_x,
    output logic signed [aafp_pkg::ACC_W-1:0]  o_z
);
    localparam int N = (STAGES > aafp_pkg::MAX_STAGES) ? aafp_pkg::MAX_STAGES : STAGES;

    aafp_pkg::t_vec v [0:N];
    aafp_pkg::t_vec r_pre;
    logic           r_zero;
    logic [N-1:0]   r_zp;
    logic signed [aafp_pkg::VEC_W-1:0] xg, yg;

    assign xg = aafp_pkg::VEC_W'(i_x) <<< 6;
    assign yg = aafp_pkg::VEC_W'(i_y) <<< 6;

    always_ff @(posedge i_clk) begin
        r_zero <= (i_x == 0) && (i_y == 0);
        if (xg < 0) begin
            if (yg >= 0) begin
                r_pre.x <= yg;
                r_pre.y <= -xg;
                r_pre.z <= aafp_pkg::ACC_W'(90) <<< aafp_pkg::ACC_FRAC;
            end else begin
                r_pre.x <= -yg;
                r_pre.y <= xg;
                r_pre.z <= -(aafp_pkg::ACC_W'(90) <<< aafp_pkg::ACC_FRAC);
            end
        end else begin
            r_pre.x <= xg;
            r_pre.y <= yg;
            r_pre.z <= '0;
        end
        r_zp <= {r_zp[N-2:0], r_zero};
    end

    assign v[0] = r_pre;

    for (genvar g = 0; g < N; g++) begin : g_cell
        aafp_cordic_cell #(.STEP(g)) u_cell (
            .i_clk (i_clk),
            .i_vec (v[g]),
            .o_vec (v[g+1])
        );
    end

    assign o_z = r_zp[N-1] ? '0 : v[N].z;
endmodule

FILE: dv/aim_angles_checker.sv
`timescale 1ns / 100ps
module aim_angles_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [23:0] i_src_x,
    input  logic signed [23:0] i_src_y,
    input  logic signed [23:0] i_src_z,
    input  logic signed [23:0] i_dst_x,
    input  logic signed [23:0] i_dst_y,
    input  logic signed [23:0] i_dst_z,
    input  logic               o_valid,
    input  logic [15:0]        o_yaw,
    input  logic signed [14:0] o_pitch,
    input  logic [24:0]        o_distance,
    input  logic               o_coincident,
    output int                 o_pending,
    output int                 o_fail_count
);
    typedef struct packed {
        logic [15:0] yaw;
        logic [14:0] pitch;
        logic [24:0] distance;
        logic        coincident;
    } t_aim;

    localparam longint ROUND_SH = aafp_pkg::ACC_FRAC - aafp_pkg::ANGLE_FRAC_BITS;

    longint atan_deg_lut [32] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0
    };

    t_aim aim_q[$];

    function automatic longint isqrt_round(longint v);
        longint r;
        r = longint'($floor($sqrt(real'(v))));
        while (r * r > v) r--;
        while ((r + 1) * (r + 1) <= v) r++;
        if (v - r * r > r) r++;
        return r;
    endfunction

    // vectoring rotation, degrees with ACC_FRAC fraction bits
    function automatic longint atan2_deg(longint y, longint x);
        longint ang, t, xs, ys;
        int n;
        ang = 0;
        if (x == 0 && y == 0) return 0;
        x = x * 64;
        y = y * 64;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t;
                ang = 90 <<< aafp_pkg::ACC_FRAC;
            end else begin
                t = x; x = -y; y = t;
                ang = -(90 <<< aafp_pkg::ACC_FRAC);
            end
        end
        n = (aafp_pkg::CORDIC_STAGES > 32) ? 32 : aafp_pkg::CORDIC_STAGES;
        for (int i = 0; i < n; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; ang += atan_deg_lut[i];
            end else begin
                x = x - ys; y = y + xs; ang -= atan_deg_lut[i];
            end
        end
        return ang;
    endfunction

    function automatic longint angle_round(longint z);
        return (z + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
    endfunction

    function automatic t_aim predict_aim(longint sx, sy, sz, tx, ty, tz);
        longint dx, dy, dz, hsq, h, yaw, pitch, full;
        t_aim r;
        dx = tx - sx;
        dy = ty - sy;
        dz = tz - sz;
        hsq = dx * dx + dy * dy;
        h = isqrt_round(hsq);
        full = 180 <<< aafp_pkg::ANGLE_FRAC_BITS;
        yaw = full - angle_round(atan2_deg(dx, dy));
        pitch = angle_round(atan2_deg(dz, h));
        if (yaw < 0) yaw = 0;
        if (yaw > 2 * full) yaw = 2 * full;
        if (pitch > (90 <<< aafp_pkg::ANGLE_FRAC_BITS))
            pitch = 90 <<< aafp_pkg::ANGLE_FRAC_BITS;
        if (pitch < -(90 <<< aafp_pkg::ANGLE_FRAC_BITS))
            pitch = -(90 <<< aafp_pkg::ANGLE_FRAC_BITS);
        r.coincident = (dx == 0 && dy == 0 && dz == 0);
        if (r.coincident) pitch = 0;
        r.yaw = yaw[15:0];
        r.pitch = pitch[14:0];
        r.distance = 25'(isqrt_round(hsq + dz * dz));
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_aim e;
        if (i_rst_n && o_valid) begin
            if (aim_q.size() == 0) begin
                $error("result beat with nothing expected");
                o_fail_count <= o_fail_count + 1;
            end else begin
                e = aim_q.pop_front();
                if (o_yaw !== e.yaw || o_pitch !== e.pitch || o_distance !== e.distance
                        || o_coincident !== e.coincident) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_yaw !== e.yaw)
                        $error("yaw: expected %0d, actual %0d", e.yaw, o_yaw);
                    if (o_pitch !== e.pitch)
                        $error("pitch: expected %0d, actual %0d",
                            $signed(e.pitch), o_pitch);
                    if (o_distance !== e.distance)
                        $error("distance: expected %0d, actual %0d", e.distance, o_distance);
                    if (o_coincident !== e.coincident)
                        $error("coincident: expected %0d, actual %0d",
                            e.coincident, o_coincident);
                end
            end
        end
        if (i_rst_n && start && !busy)
            aim_q.push_back(predict_aim(i_src_x, i_src_y, i_src_z,
                i_dst_x, i_dst_y, i_dst_z));
        o_pending <= aim_q.size();
    end
endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    localparam int LATENCY = 1 + 27 + 2 + aafp_pkg::CORDIC_STAGES + 1;
    localparam int N_RANDOM = 1530;
    localparam int CYCLE_LIMIT = 200000;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic signed [23:0] i_src_x = 0, i_src_y = 0, i_src_z = 0;
    logic signed [23:0] i_dst_x = 0, i_dst_y = 0, i_dst_z = 0;
    logic               o_valid;
    logic [15:0]        o_yaw;
    logic signed [14:0] o_pitch;
    logic [24:0]        o_distance;
    logic               o_coincident;
    int                 pending, fail_count, cycles = 0;
    bit                 no_gaps;

    always #2 i_clk = ~i_clk;

    aim_angles_from_points uut (.*);
    aim_angles_checker u_checker (.*, .o_pending(pending), .o_fail_count(fail_count));

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_points(input int sx, sy, sz, tx, ty, tz);
        bit acc;
        int gap;
        i_src_x <= 24'(sx); i_src_y <= 24'(sy); i_src_z <= 24'(sz);
        i_dst_x <= 24'(tx); i_dst_y <= 24'(ty); i_dst_z <= 24'(tz);
        start <= 1;
        do begin
            acc = !busy;
            @(negedge i_clk);
        end while (!acc);
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic logic signed [23:0] rnd_delta(logic signed [23:0] base);
        int d;
        d = $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(0, 2000)) - 1000;
        return base + 24'(d);
    endfunction

    initial begin
        logic signed [23:0] sx, sy, sz, tx, ty, tz;
        no_gaps = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // directed
        send_points(0, 0, 0, 0, 0, 0);
        send_points(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        send_points(0, 0, 0, 0, 0, 256);
        send_points(0, 0, 0, 0, 0, -256);
        send_points(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF);
        send_points(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_points(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000);
        send_points(24'h800000, 24'h7FFFFF, 0, 24'h7FFFFF, 24'h800000, 0);
        send_points(0, 0, 0, 256, 0, 0);
        send_points(0, 0, 0, -256, 0, 0);
        send_points(0, 0, 0, 0, 256, 0);
        send_points(0, 0, 0, 0, -256, 0);
        send_points(0, 0, 0, -256, -256, 0);
        send_points(0, 0, 0, 256, -256, 100);
        send_points(0, 0, 0, -256, 256, -100);
        send_points(0, 0, 0, 1, 0, 0);
        send_points(0, 0, 0, 0, -1, 0);
        send_points(0, 0, 0, -1, 1, 1);
        send_points(5, -7, 3, 5, -7, 4);
        send_points(0, 0, 0, 0, 24'h7FFFFF, 1);
        // random
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0) no_gaps = $urandom_range(0, 2) == 0;
            if (n == N_RANDOM / 2) begin
                start <= 0;
                while (pending != 0) @(negedge i_clk);
            end
            sx = 24'($urandom); sy = 24'($urandom); sz = 24'($urandom);
            case ($urandom_range(0, 3))
                0: begin
                    tx = 24'($urandom); ty = 24'($urandom); tz = 24'($urandom);
                end
                1: begin
                    tx = rnd_delta(sx); ty = rnd_delta(sy); tz = rnd_delta(sz);
                end
                2: begin
                    tx = $urandom_range(0, 1) ? sx : 24'($urandom);
                    ty = $urandom_range(0, 1) ? sy : 24'($urandom);
                    tz = $urandom_range(0, 1) ? sz : 24'($urandom);
                end
                default: begin
                    sx = 24'(int'($urandom_range(0, 4096)) - 2048);
                    sy = 24'(int'($urandom_range(0, 4096)) - 2048);
                    sz = 24'(int'($urandom_range(0, 4096)) - 2048);
                    tx = 24'(int'($urandom_range(0, 4096)) - 2048);
                    ty = 24'(int'($urandom_range(0, 4096)) - 2048);
                    tz = 24'(int'($urandom_range(0, 4096)) - 2048);
                end
            endcase
            send_points(sx, sy, sz, tx, ty, tz);
        end
        start <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hdl
hdl/aafp_pkg.sv
hdl/aafp_sqrt_cell.sv
hdl/aafp_cordic_cell.sv
hdl/aafp_cordic.sv
hdl/aim_angles_from_points.sv
dv/aim_angles_checker.sv
dv/tb_top.sv
